### rtl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// Byte block sorter package
// Shared constants and the command and status types between controller and
// datapath.
// ----------------------------------------------------------------------------
package bbs_pkg;

	// Default number of characters in one block.
	localparam int BLOCK_LENGTH_DEF = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;        // An item is taken: place its character in the chain.
		logic finish;        // The taken item closes the block.
		logic emit;          // Shift the smallest character out as a result.
		logic emit_last;     // The character shifted out now ends the block.
		logic report_error;  // Issue the single length error result.
	} bbs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic one_short;     // The store holds one character less than a block.
		logic overflow;      // A character was dropped because the store was full.
	} bbs_status_t;

endpackage

### rtl/bbs_datapath.sv
// ----------------------------------------------------------------------------
// Byte block sorter datapath
// Insertion chain that keeps the characters in ascending signed order, the
// fill count, the overflow flag and the result registers.
// ----------------------------------------------------------------------------
module bbs_datapath #(
	parameter int BLOCK_LENGTH = bbs_pkg::BLOCK_LENGTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bbs_pkg::bbs_cmd_t  cmd,
	input  logic signed [7:0]  value,
	output bbs_pkg::bbs_status_t status,
	output logic               strobe,
	output logic signed [7:0]  sorted_value,
	output logic               run_end,
	output logic               length_error
);
	import bbs_pkg::*;

	localparam int CW = $clog2(BLOCK_LENGTH + 1);

	logic signed [7:0] cell_q [BLOCK_LENGTH];
	logic [CW-1:0]     fill_q;
	logic              overflow_q;
	logic              has_room;
	logic [BLOCK_LENGTH-1:0] gt;
	logic              strobe_q;
	logic signed [7:0] sorted_value_q;
	logic              run_end_q;
	logic              length_error_q;

	assign has_room = (fill_q != CW'(BLOCK_LENGTH));

	// Each cell sits at a fixed place in the chain and looks at its neighbors.
	for (genvar i = 0; i < BLOCK_LENGTH; i++) begin : g_cell
		logic              prev_gt;
		logic signed [7:0] prev_val;
		logic signed [7:0] next_val;

		assign gt[i] = (fill_q > CW'(i)) && (cell_q[i] > value);

		if (i == 0) begin : g_head
			assign prev_gt  = 1'b0;
			assign prev_val = value;
		end else begin : g_body
			assign prev_gt  = gt[i-1];
			assign prev_val = cell_q[i-1];
		end

		if (i == BLOCK_LENGTH - 1) begin : g_tail
			assign next_val = cell_q[i];
		end else begin : g_inner
			assign next_val = cell_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert && has_room) begin
				if (prev_gt) begin
					cell_q[i] <= prev_val;
				end else if (gt[i] || fill_q == CW'(i)) begin
					cell_q[i] <= value;
				end
			end else if (cmd.emit) begin
				cell_q[i] <= next_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.insert) begin
			if (cmd.finish) begin
				fill_q     <= '0;
				overflow_q <= 1'b0;
			end else if (has_room) begin
				fill_q <= fill_q + 1'b1;
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit | cmd.report_error;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sorted_value_q <= cell_q[0];
			run_end_q      <= cmd.emit_last;
			length_error_q <= 1'b0;
		end else if (cmd.report_error) begin
			sorted_value_q <= '0;
			run_end_q      <= 1'b1;
			length_error_q <= 1'b1;
		end
	end

	assign status.one_short = (fill_q == CW'(BLOCK_LENGTH - 1));
	assign status.overflow  = overflow_q;

	assign strobe       = strobe_q;
	assign sorted_value = sorted_value_q;
	assign run_end      = run_end_q;
	assign length_error = length_error_q;

endmodule

### rtl/bbs_ctrl.sv
// ----------------------------------------------------------------------------
// Byte block sorter controller
// Takes items, decides at the final item between emission and a length
// error, and paces the emission of the sorted block.
// ----------------------------------------------------------------------------
module bbs_ctrl #(
	parameter int BLOCK_LENGTH = bbs_pkg::BLOCK_LENGTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 final_req,
	input  bbs_pkg::bbs_status_t status,
	output bbs_pkg::bbs_cmd_t    cmd,
	output logic                 busy
);
	import bbs_pkg::*;

	localparam int NW = $clog2(BLOCK_LENGTH);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t        state_q;
	state_t        state_d;
	logic [NW-1:0] count_q;
	logic          block_ok;
	logic          count_last;

	assign block_ok   = status.one_short && !status.overflow;
	assign count_last = (count_q == NW'(BLOCK_LENGTH - 1));

	always_comb begin
		state_d          = state_q;
		cmd.insert       = 1'b0;
		cmd.finish       = 1'b0;
		cmd.emit         = 1'b0;
		cmd.emit_last    = 1'b0;
		cmd.report_error = 1'b0;
		busy             = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.insert = start;
				cmd.finish = start && final_req;
				if (start && final_req) begin
					if (block_ok) begin
						state_d = ST_EMIT;
					end else begin
						cmd.report_error = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				busy          = 1'b1;
				cmd.emit      = 1'b1;
				cmd.emit_last = count_last;
				if (count_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT) begin
				count_q <= count_last ? '0 : count_q + 1'b1;
			end
		end
	end

endmodule

### rtl/byte_block_sorter.sv
// ----------------------------------------------------------------------------
// Byte block sorter
// Collects a block of signed bytes into an insertion chain and emits the
// block in ascending signed order, or one length error result.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                  Transfer
//  --------  ---------------------------------------  -------------------------
//  item      start, busy, value, final_req            start high, busy low
//  result    strobe, sorted_value, run_end,           strobe high, one cycle,
//            length_error                             no back pressure
//
// The chain places its character at the accepting edge, so items may follow
// back to back while busy is low.
// A final item that closes a block of exactly BLOCK_LENGTH characters raises busy
// for the whole emission; the results follow on consecutive cycles through the
// emit command and the result registers, the last, with run_end, in the cycle in
// which busy falls. A block of wrong length gives one error result in the cycle right
// after the final item transfer and busy stays low. The receiver cannot stall.
// Reset clears the fill count, the overflow flag, the strobe register and the controller only.
//
module byte_block_sorter #(
	parameter int BLOCK_LENGTH = bbs_pkg::BLOCK_LENGTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic signed [7:0] value,
	input  logic              final_req,
	output logic              strobe,
	output logic signed [7:0] sorted_value,
	output logic              run_end,
	output logic              length_error
);
	import bbs_pkg::*;

	bbs_cmd_t    cmd;
	bbs_status_t status;

	// The controller owns the handshake and the emission count.
	bbs_ctrl #(
		.BLOCK_LENGTH(BLOCK_LENGTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.final_req (final_req),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	// The datapath holds the sorted chain and drives the result registers.
	bbs_datapath #(
		.BLOCK_LENGTH(BLOCK_LENGTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.status       (status),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.run_end      (run_end),
		.length_error (length_error)
	);

	// Emission only ever starts from a final item transfer.
	a_emit_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && final_req))
		else $error("emission started without a final item");

	// The end of emission coincides with the last, error-free result.
	a_emit_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && run_end && !length_error))
		else $error("emission ended without the closing result");

	// Results in the middle of a block are only produced while emitting.
	a_mid_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !run_end) |-> (busy && !length_error))
		else $error("mid-block result outside emission");

	// A length error answers a final item transfer of the previous cycle.
	a_error_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && length_error) |-> $past(start && final_req && !busy))
		else $error("length error without a final item");

endmodule
